@@ src/hmti_pkg.sv @@
package hmti_pkg;

    localparam int VAL_W   = 32;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int DIVN_W  = PROD_W + 1;
    localparam int DIVD_W  = VAL_W + 1;
    localparam int PTS_W   = 5;
    localparam int PIDX_W  = 4;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_MEAN   = 2'd1;
    localparam logic [1:0] CMD_DIRECT = 2'd2;

    localparam logic [PTS_W-1:0] PTS_RESET = 5'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HMUL,
        ST_HDIV,
        ST_HWAIT,
        ST_FIRST,
        ST_PRIME,
        ST_SCAN,
        ST_IMUL,
        ST_IDIV,
        ST_IWAIT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ src/hmti_ram.sv @@
module hmti_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/hmti_div.sv @@
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in VAL_W bits, i.e. dividend[top] < divisor.
module hmti_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [hmti_pkg::DIVN_W-1:0]   dividend,
    input  logic [hmti_pkg::DIVD_W-1:0]   divisor,
    output hmti_pkg::div_status_t         status,
    output logic [hmti_pkg::VAL_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(hmti_pkg::VAL_W + 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [hmti_pkg::DIVD_W-1:0]   rem_reg;
    logic [hmti_pkg::DIVD_W-1:0]   den_reg;
    logic [hmti_pkg::VAL_W-1:0]    q_reg;
    logic [hmti_pkg::DIVD_W:0]     rem_shift;
    logic [hmti_pkg::DIVD_W:0]     rem_diff;
    logic                          fits;

    assign rem_shift = {rem_reg, q_reg[hmti_pkg::VAL_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(hmti_pkg::VAL_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[hmti_pkg::DIVN_W-1:hmti_pkg::VAL_W];
            q_reg   <= dividend[hmti_pkg::VAL_W-1:0];
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // low bits of the dividend shift out as quotient bits shift in
            if (fits)
            begin
                rem_reg <= rem_diff[hmti_pkg::DIVD_W-1:0];
            end
            else
            begin
                rem_reg <= rem_shift[hmti_pkg::DIVD_W-1:0];
            end
            q_reg <= {q_reg[hmti_pkg::VAL_W-2:0], fits};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = q_reg;

endmodule

@@ src/harmonic_mean_table_interpolator.sv @@
// Command-style block: an item is taken when start is high and busy is low;
// busy then stays high until a mean or direct item is finished. A load item
// (cmd 0) writes one breakpoint and leaves busy low. A direct item (cmd 2)
// scans the table pairs in order until the first hit, at one entry per cycle
// from the table RAM read port, over at most n-1 pairs where n is table_points
// clamped to 2 .. TABLE_DEPTH, and interpolates on a hit; a mean item (cmd 1)
// with a neighbor and a nonzero sum first runs the 2ab/(a+b) division.
// Both divisions run on one shared 32-step restoring divider and both
// products on one 32x32 multiplier. Each result is shown for exactly one
// cycle with result_valid high, in the first cycle with busy low again; the
// receiver cannot stall it. Breakpoints must be written before they are
// looked up. table_points may only be written while busy is low.
module harmonic_mean_table_interpolator #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         cmd,
    input  logic [hmti_pkg::PIDX_W-1:0]        point_index,
    input  logic [hmti_pkg::VAL_W-1:0]         value_a,
    input  logic [hmti_pkg::VAL_W-1:0]         value_b,
    input  logic                               has_neighbor,
    input  logic signed [hmti_pkg::VAL_W-1:0]  point_y,
    output logic                               result_valid,
    output logic signed [hmti_pkg::VAL_W-1:0]  result_value,
    output logic [hmti_pkg::VAL_W-1:0]         mean_value,
    output logic                               in_range,
    output logic                               zero_sum,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hmti_pkg::PTS_W-1:0]         cfg_data
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int VW    = hmti_pkg::VAL_W;
    localparam int EXT_W = AW + hmti_pkg::PIDX_W;
    localparam int TPX_W = CW + hmti_pkg::PTS_W;

    hmti_pkg::state_t state_reg, state_next;

    logic [hmti_pkg::PTS_W-1:0]   tp_reg;
    logic [CW-1:0]                n_eff;
    logic [TPX_W-1:0]             tp_ext;

    logic [VW-1:0]                t_reg;
    logic                         zs_reg;
    logic [VW-1:0]                op_a_reg;
    logic [VW-1:0]                op_b_reg;
    logic [hmti_pkg::PROD_W-1:0]  prod_reg;
    logic [hmti_pkg::DIVD_W-1:0]  sum_reg;
    logic [VW-1:0]                dx_reg;
    logic [VW-1:0]                prev_x_reg;
    logic signed [VW-1:0]         prev_y_reg;
    logic signed [VW-1:0]         y0_reg;
    logic                         neg_reg;
    logic [VW-1:0]                q_reg;
    logic [CW-1:0]                cnt_reg;

    logic                         res_valid_reg;
    logic signed [VW-1:0]         res_value_reg;
    logic [VW-1:0]                res_mean_reg;
    logic                         res_range_reg;
    logic                         res_zs_reg;

    logic                         accept;
    logic                         mean_div;
    logic [EXT_W-1:0]             idx_ext;
    logic                         ram_we;
    logic [AW-1:0]                ram_raddr;
    logic [2*VW-1:0]              ram_rdata;
    logic [VW-1:0]                cur_x;
    logic signed [VW-1:0]         cur_y;
    logic                         hit;
    logic                         last_pair;
    logic signed [VW:0]           dy;
    logic [VW:0]                  dy_mag;

    logic                         div_start;
    logic [hmti_pkg::DIVN_W-1:0]  div_n;
    logic [hmti_pkg::DIVD_W-1:0]  div_d;
    hmti_pkg::div_status_t        div_st;
    logic [VW-1:0]                div_q;

    logic signed [VW+1:0]         sum_v;
    logic signed [VW-1:0]         sat_v;

    assign busy      = state_reg != hmti_pkg::ST_IDLE;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign mean_div  = has_neighbor && ((value_a | value_b) != '0);

    // clamp the point count into 2 .. TABLE_DEPTH
    assign tp_ext = TPX_W'(tp_reg);
    always_comb
    begin
        if (tp_ext < TPX_W'(2))
        begin
            n_eff = CW'(2);
        end
        else if (tp_ext > TPX_W'(TABLE_DEPTH))
        begin
            n_eff = CW'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = tp_ext[CW-1:0];
        end
    end

    // breakpoint table, one entry {x, y}
    assign idx_ext = EXT_W'(point_index);
    assign ram_we  = accept && (cmd == hmti_pkg::CMD_LOAD)
                     && (idx_ext < EXT_W'(TABLE_DEPTH));

    hmti_ram #(
        .WIDTH (2 * VW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_ext[AW-1:0]),
        .wdata ({value_a, point_y}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur_x     = ram_rdata[2*VW-1:VW];
    assign cur_y     = ram_rdata[VW-1:0];
    assign hit       = (t_reg >= prev_x_reg) && (t_reg < cur_x);
    assign last_pair = cnt_reg == (n_eff - CW'(1));
    assign dy        = {cur_y[VW-1], cur_y} - {prev_y_reg[VW-1], prev_y_reg};
    assign dy_mag    = dy[VW] ? (~dy + (VW+1)'(1)) : dy;

    hmti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .status   (div_st),
        .quotient (div_q)
    );

    // y0 +/- q, then saturate to signed 32 bits
    assign sum_v = neg_reg ? ((VW+2)'(y0_reg) - $signed({2'b00, q_reg}))
                           : ((VW+2)'(y0_reg) + $signed({2'b00, q_reg}));
    always_comb
    begin
        if (sum_v > (VW+2)'(signed'({1'b0, {(VW-1){1'b1}}})))
        begin
            sat_v = {1'b0, {(VW-1){1'b1}}};
        end
        else if (sum_v < $signed({{3{1'b1}}, {(VW-1){1'b0}}}))
        begin
            sat_v = {1'b1, {(VW-1){1'b0}}};
        end
        else
        begin
            sat_v = sum_v[VW-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hmti_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        hmti_pkg::CMD_MEAN:
                        begin
                            state_next = mean_div ? hmti_pkg::ST_HMUL : hmti_pkg::ST_FIRST;
                        end
                        hmti_pkg::CMD_DIRECT: state_next = hmti_pkg::ST_FIRST;
                        default:              state_next = hmti_pkg::ST_IDLE;
                    endcase
                end
            end
            hmti_pkg::ST_HMUL:  state_next = hmti_pkg::ST_HDIV;
            hmti_pkg::ST_HDIV:  state_next = hmti_pkg::ST_HWAIT;
            hmti_pkg::ST_HWAIT:
            begin
                if (div_st.done)
                begin
                    state_next = hmti_pkg::ST_FIRST;
                end
            end
            hmti_pkg::ST_FIRST: state_next = hmti_pkg::ST_PRIME;
            hmti_pkg::ST_PRIME: state_next = hmti_pkg::ST_SCAN;
            hmti_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = hmti_pkg::ST_IMUL;
                end
                else if (last_pair)
                begin
                    state_next = hmti_pkg::ST_IDLE;
                end
            end
            hmti_pkg::ST_IMUL:  state_next = hmti_pkg::ST_IDIV;
            hmti_pkg::ST_IDIV:  state_next = hmti_pkg::ST_IWAIT;
            hmti_pkg::ST_IWAIT:
            begin
                if (div_st.done)
                begin
                    state_next = hmti_pkg::ST_FIN;
                end
            end
            hmti_pkg::ST_FIN:   state_next = hmti_pkg::ST_IDLE;
            default:            state_next = hmti_pkg::ST_IDLE;
        endcase
    end

    // control outputs of the sequencer
    always_comb
    begin
        ram_raddr = '0;
        div_start = 1'b0;
        div_n     = {1'b0, prod_reg};
        div_d     = {1'b0, dx_reg};
        case (state_reg)
            hmti_pkg::ST_PRIME: ram_raddr = AW'(1);
            hmti_pkg::ST_SCAN:  ram_raddr = cnt_reg[AW-1:0] + AW'(1);
            hmti_pkg::ST_HDIV:
            begin
                // floor(2ab / (a+b))
                div_start = 1'b1;
                div_n     = {prod_reg, 1'b0};
                div_d     = sum_reg;
            end
            hmti_pkg::ST_IDIV:  div_start = 1'b1;
            default:            ram_raddr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hmti_pkg::ST_IDLE;
            tp_reg        <= hmti_pkg::PTS_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= ((state_reg == hmti_pkg::ST_SCAN) && !hit && last_pair)
                             || (state_reg == hmti_pkg::ST_FIN);
            if (cfg_valid && cfg_ready)
            begin
                tp_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            hmti_pkg::ST_IDLE:
            begin
                op_a_reg <= value_a;
                op_b_reg <= value_b;
                sum_reg  <= {1'b0, value_a} + {1'b0, value_b};
                zs_reg   <= (cmd == hmti_pkg::CMD_MEAN) && has_neighbor && !mean_div;
                t_reg    <= (cmd == hmti_pkg::CMD_DIRECT) ? value_a : '0;
            end
            hmti_pkg::ST_HMUL:  prod_reg <= op_a_reg * op_b_reg;
            hmti_pkg::ST_HWAIT:
            begin
                if (div_st.done)
                begin
                    t_reg <= div_q;
                end
            end
            hmti_pkg::ST_PRIME:
            begin
                prev_x_reg <= cur_x;
                prev_y_reg <= cur_y;
                cnt_reg    <= CW'(1);
            end
            hmti_pkg::ST_SCAN:
            begin
                prev_x_reg <= cur_x;
                prev_y_reg <= cur_y;
                cnt_reg    <= cnt_reg + CW'(1);
                y0_reg     <= prev_y_reg;
                neg_reg    <= dy[VW];
                op_a_reg   <= dy_mag[VW-1:0];
                op_b_reg   <= t_reg - prev_x_reg;
                dx_reg     <= cur_x - prev_x_reg;
                if (!hit && last_pair)
                begin
                    res_value_reg <= '0;
                    res_mean_reg  <= t_reg;
                    res_range_reg <= 1'b0;
                    res_zs_reg    <= zs_reg;
                end
            end
            hmti_pkg::ST_IMUL:  prod_reg <= op_a_reg * op_b_reg;
            hmti_pkg::ST_IWAIT:
            begin
                if (div_st.done)
                begin
                    q_reg <= div_q;
                end
            end
            hmti_pkg::ST_FIN:
            begin
                res_value_reg <= sat_v;
                res_mean_reg  <= t_reg;
                res_range_reg <= 1'b1;
                res_zs_reg    <= zs_reg;
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign result_valid = res_valid_reg;
    assign result_value = res_value_reg;
    assign mean_value   = res_mean_reg;
    assign in_range     = res_range_reg;
    assign zero_sum     = res_zs_reg;

`ifndef SYNTHESIS
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without an item in progress");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !in_range) |-> (result_value == '0))
        else $error("out-of-range result is not zero");

    a_zero_sum_mean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && zero_sum) |-> (mean_value == '0))
        else $error("zero sum with nonzero mean");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == hmti_pkg::ST_HWAIT || state_reg == hmti_pkg::ST_IWAIT))
        else $error("divider finished while sequencer was not waiting");
`endif

endmodule

@@ tb/sv/harmonic_mean_table_interpolator_checker.sv @@
module harmonic_mean_table_interpolator_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic [1:0]                         cmd,
    input  logic [hmti_pkg::PIDX_W-1:0]        point_index,
    input  logic [hmti_pkg::VAL_W-1:0]         value_a,
    input  logic [hmti_pkg::VAL_W-1:0]         value_b,
    input  logic                               has_neighbor,
    input  logic signed [hmti_pkg::VAL_W-1:0]  point_y,
    input  logic                               result_valid,
    input  logic signed [hmti_pkg::VAL_W-1:0]  result_value,
    input  logic [hmti_pkg::VAL_W-1:0]         mean_value,
    input  logic                               in_range,
    input  logic                               zero_sum,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [hmti_pkg::PTS_W-1:0]         cfg_data,
    output int                                 mismatches,
    output int                                 pending,
    output int                                 items_taken,
    output int                                 cfg_writes,
    output int                                 results_seen,
    output int                                 hits_seen,
    output int                                 zero_sums_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_LO = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic signed [31:0] value;
        logic [31:0]        mean;
        logic               found;
        logic               zero;
    } interp_result_t;

    logic [31:0]                 tab_x [TABLE_DEPTH];
    logic signed [31:0]          tab_y [TABLE_DEPTH];
    logic [hmti_pkg::PTS_W-1:0]  points_cfg;
    interp_result_t              pending_results [$];

    // floor(2ab/(a+b)) over the full 64-bit product; caller excludes a+b == 0
    function automatic logic [31:0] harmonic_mean(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] sum, prod, quo, rem, m;
        sum  = {32'd0, a} + {32'd0, b};
        prod = {32'd0, a} * {32'd0, b};
        quo  = prod / sum;
        rem  = prod % sum;
        m    = {quo[62:0], 1'b0} + (({rem[62:0], 1'b0} >= sum) ? 64'd1 : 64'd0);
        return m[31:0];
    endfunction

    function automatic interp_result_t interp_lookup(input logic [31:0] t);
        interp_result_t r;
        int             n;
        int             j;
        logic [31:0]    x0, x1, dt, dx;
        longint         y0, y1, dy, v;
        logic [63:0]    mag, q;
        r      = '0;
        r.mean = t;
        n      = int'(points_cfg);
        if (n < 2)
            n = 2;
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        for (j = 0; j + 1 < n && !r.found; j++)
        begin
            x0 = tab_x[j];
            x1 = tab_x[j + 1];
            if (t >= x0 && t < x1)
            begin
                y0  = tab_y[j];
                y1  = tab_y[j + 1];
                dy  = y1 - y0;
                dt  = t - x0;
                dx  = x1 - x0;
                mag = (dy < 0) ? -dy : dy;
                q   = (mag * {32'd0, dt}) / {32'd0, dx};
                v   = (dy < 0) ? y0 - longint'(q) : y0 + longint'(q);
                if (v > SAT_HI)
                    v = SAT_HI;
                if (v < SAT_LO)
                    v = SAT_LO;
                r.value = v[31:0];
                r.found = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        interp_result_t want;
        logic [31:0]    arg;
        logic           zs;
        if (!rst_n)
        begin
            pending_results.delete();
            points_cfg     = hmti_pkg::PTS_RESET;
            mismatches     = 0;
            pending        = 0;
            items_taken    = 0;
            cfg_writes     = 0;
            results_seen   = 0;
            hits_seen      = 0;
            zero_sums_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                points_cfg = cfg_data;
                cfg_writes++;
            end

            // results leave before a new item enters: the oldest expectation is first
            if (result_valid)
            begin
                results_seen++;
                if (in_range)
                    hits_seen++;
                if (zero_sum)
                    zero_sums_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: result_value %0d mean_value %0h",
                           result_value, mean_value);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result_value !== want.value)
                    begin
                        $error("result_value: expected %0d, got %0d",
                               $signed(want.value), result_value);
                        mismatches++;
                    end
                    if (mean_value !== want.mean)
                    begin
                        $error("mean_value: expected %0h, got %0h", want.mean, mean_value);
                        mismatches++;
                    end
                    if (in_range !== want.found)
                    begin
                        $error("in_range: expected %0b, got %0b", want.found, in_range);
                        mismatches++;
                    end
                    if (zero_sum !== want.zero)
                    begin
                        $error("zero_sum: expected %0b, got %0b", want.zero, zero_sum);
                        mismatches++;
                    end
                end
            end

            if (start && !busy)
            begin
                items_taken++;
                arg = '0;
                zs  = 1'b0;
                case (cmd)
                    hmti_pkg::CMD_LOAD:
                    begin
                        if (int'(point_index) < TABLE_DEPTH)
                        begin
                            tab_x[point_index] = value_a;
                            tab_y[point_index] = point_y;
                        end
                    end
                    hmti_pkg::CMD_MEAN, hmti_pkg::CMD_DIRECT:
                    begin
                        if (cmd == hmti_pkg::CMD_DIRECT)
                            arg = value_a;
                        else if (has_neighbor && ({1'b0, value_a} + {1'b0, value_b}) == '0)
                            zs = 1'b1;
                        else if (has_neighbor)
                            arg = harmonic_mean(value_a, value_b);
                        want      = interp_lookup(arg);
                        want.zero = zs;
                        pending_results.insert(pending_results.size(), want);
                    end
                    default: ;
                endcase
            end
            pending = pending_results.size();
        end
    end

endmodule

@@ tb/sv/harmonic_mean_table_interpolator_tb.sv @@
module harmonic_mean_table_interpolator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         DEPTH       = 16;
    localparam int         EVAL_ITEMS  = 1600;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic [1:0]                         cmd;
    logic [hmti_pkg::PIDX_W-1:0]        point_index;
    logic [hmti_pkg::VAL_W-1:0]         value_a;
    logic [hmti_pkg::VAL_W-1:0]         value_b;
    logic                               has_neighbor;
    logic signed [hmti_pkg::VAL_W-1:0]  point_y;
    logic                               result_valid;
    logic signed [hmti_pkg::VAL_W-1:0]  result_value;
    logic [hmti_pkg::VAL_W-1:0]         mean_value;
    logic                               in_range;
    logic                               zero_sum;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [hmti_pkg::PTS_W-1:0]         cfg_data;

    int mismatches, pending, items_taken, cfg_writes;
    int results_seen, hits_seen, zero_sums_seen;

    logic [31:0] shadow_x [DEPTH];
    int          cur_points;
    int          burst_left;
    bit          no_idle;
    int          evals_sent;
    int          tables_loaded;

    harmonic_mean_table_interpolator #(
        .TABLE_DEPTH (DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .point_index  (point_index),
        .value_a      (value_a),
        .value_b      (value_b),
        .has_neighbor (has_neighbor),
        .point_y      (point_y),
        .result_valid (result_valid),
        .result_value (result_value),
        .mean_value   (mean_value),
        .in_range     (in_range),
        .zero_sum     (zero_sum),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    harmonic_mean_table_interpolator_checker #(
        .TABLE_DEPTH (DEPTH)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .point_index    (point_index),
        .value_a        (value_a),
        .value_b        (value_b),
        .has_neighbor   (has_neighbor),
        .point_y        (point_y),
        .result_valid   (result_valid),
        .result_value   (result_value),
        .mean_value     (mean_value),
        .in_range       (in_range),
        .zero_sum       (zero_sum),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending        (pending),
        .items_taken    (items_taken),
        .cfg_writes     (cfg_writes),
        .results_seen   (results_seen),
        .hits_seen      (hits_seen),
        .zero_sums_seen (zero_sums_seen)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #30_000_000;
        $error("timeout: %0d results still outstanding", pending);
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [31:0] random_y();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 32'h0001_0000);
            default: return $urandom;
        endcase
    endfunction

    // argument aimed mostly inside an interval of the points in use
    function automatic logic [31:0] pick_arg();
        int          j;
        logic [31:0] lo, hi;
        j  = $urandom_range(0, cur_points - 2);
        lo = shadow_x[j];
        hi = shadow_x[j + 1];
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return lo;
            2: return hi - 32'd1;
            3: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            default: return (hi > lo) ? lo + $urandom_range(0, hi - lo - 1) : lo;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] c, input logic [3:0] idx, input logic [31:0] a,
                             input logic [31:0] b, input logic nb, input logic [31:0] y);
        int taken;
        int gap;
        taken        = items_taken;
        cmd          = c;
        point_index  = idx;
        value_a      = a;
        value_b      = b;
        has_neighbor = nb;
        point_y      = y;
        start        = 1'b1;
        do @(negedge clk); while (items_taken == taken);
        if (c == hmti_pkg::CMD_LOAD)
            shadow_x[idx] = a;
        if (!no_idle)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
                                                  : $urandom_range(1, 12);
                start        = 1'b0;
                cmd          = 2'($urandom);
                point_index  = 4'($urandom);
                value_a      = $urandom;
                value_b      = $urandom;
                has_neighbor = 1'($urandom);
                point_y      = $urandom;
                repeat (gap) @(negedge clk);
                burst_left = $urandom_range(0, 12);
            end
        end
    endtask

    task automatic wait_idle();
        start = 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        // a trailing load has no result; let it drain
        repeat (4) @(negedge clk);
    endtask

    task automatic write_points(input logic [4:0] v);
        int n;
        wait_idle();
        n         = cfg_writes;
        cfg_data  = v;
        cfg_valid = 1'b1;
        do @(negedge clk); while (cfg_writes == n);
        cfg_valid  = 1'b0;
        cur_points = (v < 2) ? 2 : (v > DEPTH) ? DEPTH : int'(v);
    endtask

    task automatic load_table(input int mode);
        logic [31:0] xs [DEPTH];
        logic [31:0] swap, base, step;
        int          i, k;
        base = $urandom_range(0, 32'hFFFF_0000);
        step = $urandom_range(1, 32'h1000_0000);
        for (i = 0; i < DEPTH; i++)
        begin
            case (mode)
                1: xs[i] = base + $urandom_range(0, 4000);
                2: xs[i] = i * step;
                default: xs[i] = $urandom;
            endcase
        end
        // mode 3 keeps the table unsorted
        if (mode != 3)
            for (i = 0; i < DEPTH - 1; i++)
                for (k = 0; k < DEPTH - 1 - i; k++)
                    if (xs[k] > xs[k + 1])
                    begin
                        swap      = xs[k];
                        xs[k]     = xs[k + 1];
                        xs[k + 1] = swap;
                    end
        for (i = 0; i < DEPTH; i++)
            send_item(hmti_pkg::CMD_LOAD, 4'(i), xs[i], $urandom, 1'($urandom), random_y());
        tables_loaded++;
    endtask

    task automatic send_eval();
        logic [31:0] t;
        t = pick_arg();
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                send_item(hmti_pkg::CMD_DIRECT, 4'($urandom), t, $urandom, 1'($urandom),
                          $urandom);
            // harmonic mean of equal values is the value itself
            4, 5, 6:
                send_item(hmti_pkg::CMD_MEAN, 4'($urandom), t, t, 1'b1, $urandom);
            7:
                send_item(hmti_pkg::CMD_MEAN, 4'($urandom), t, pick_arg(), 1'b1, $urandom);
            8:
                send_item(hmti_pkg::CMD_MEAN, 4'($urandom), $urandom, $urandom, 1'($urandom),
                          $urandom);
            default:
                case ($urandom_range(0, 2))
                    0: send_item(hmti_pkg::CMD_MEAN, 4'($urandom), 32'h0, 32'h0, 1'b1,
                                 $urandom);
                    1: send_item(hmti_pkg::CMD_MEAN, 4'($urandom), 32'h0, $urandom, 1'b1,
                                 $urandom);
                    default: send_item(hmti_pkg::CMD_MEAN, 4'($urandom), $urandom, $urandom,
                                       1'b0, $urandom);
                endcase
        endcase
        evals_sent++;
    endtask

    task automatic pick_and_write_points();
        logic [4:0] v;
        case ($urandom_range(0, 9))
            0: v = 5'd2;
            1: v = 5'd16;
            2: v = 5'd0;
            3: v = 5'd1;
            4: v = 5'd17;
            5: v = 5'd31;
            default: v = 5'($urandom_range(2, 16));
        endcase
        write_points(v);
    endtask

    initial
    begin
        int i, n;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = hmti_pkg::CMD_LOAD;
        point_index  = '0;
        value_a      = '0;
        value_b      = '0;
        has_neighbor = 1'b0;
        point_y      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = hmti_pkg::PTS_RESET;
        cur_points   = 2;
        burst_left   = 0;
        no_idle      = 1'b0;
        evals_sent   = 0;
        tables_loaded = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // every slot gets written before anything is looked up
        for (i = 0; i < DEPTH; i++)
            send_item(hmti_pkg::CMD_LOAD, 4'(i),
                      (i == 0) ? 32'h0 : (i == DEPTH - 1) ? 32'hFFFF_FFFF : i << 28,
                      $urandom, 1'(i), (i % 2 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF);
        tables_loaded++;
        send_item(hmti_pkg::CMD_DIRECT, 4'd0, 32'h0, 32'h0, 1'b0, 32'h0);
        write_points(5'd16);
        send_item(hmti_pkg::CMD_DIRECT, 4'd0, 32'h3000_0000, 32'h0, 1'b0, 32'h0);
        send_item(hmti_pkg::CMD_DIRECT, 4'd0, 32'hFFFF_FFFE, 32'h0, 1'b0, 32'h0);
        send_item(hmti_pkg::CMD_DIRECT, 4'd0, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0);
        send_item(hmti_pkg::CMD_MEAN, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0);
        send_item(hmti_pkg::CMD_MEAN, 4'd0, 32'hFFFF_FFFF, 32'h1, 1'b1, 32'h0);
        send_item(hmti_pkg::CMD_MEAN, 4'd0, 32'h0, 32'h0, 1'b1, 32'h0);
        send_item(hmti_pkg::CMD_MEAN, 4'd0, 32'h0, 32'h0, 1'b0, 32'h0);
        send_item(hmti_pkg::CMD_MEAN, 4'd0, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'h0);
        send_item(CMD_UNUSED, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        write_points(5'd2);
        send_item(hmti_pkg::CMD_DIRECT, 4'd0, 32'h1000_0000, 32'h0, 1'b0, 32'h0);

        while (items_taken < EVAL_ITEMS)
        begin
            pick_and_write_points();
            if ($urandom_range(0, 2) == 0)
                load_table($urandom_range(0, 3));
            else
                repeat ($urandom_range(0, 4))
                    send_item(hmti_pkg::CMD_LOAD, 4'($urandom), $urandom, $urandom,
                              1'($urandom), random_y());
            no_idle = ($urandom_range(0, 4) == 0);
            n = $urandom_range(40, 150);
            repeat (n)
            begin
                if ($urandom_range(0, 39) == 0)
                    send_item(hmti_pkg::CMD_LOAD, 4'($urandom), pick_arg(), $urandom,
                              1'($urandom), random_y());
                else if ($urandom_range(0, 49) == 0)
                    send_item(CMD_UNUSED, 4'($urandom), $urandom, $urandom, 1'($urandom),
                              $urandom);
                else
                    send_eval();
            end
        end

        no_idle = 1'b0;
        wait_idle();
        repeat (100) @(negedge clk);

        $display("Covered %0d transactions (%0d lookups), %0d results: %0d in range, %0d zero-sum",
                 items_taken, evals_sent, results_seen, hits_seen, zero_sums_seen);
        $display("Breakpoint tables reloaded %0d times over %0d table_points settings",
                 tables_loaded, cfg_writes);
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
src/hmti_pkg.sv
src/hmti_ram.sv
src/hmti_div.sv
src/harmonic_mean_table_interpolator.sv
tb/sv/harmonic_mean_table_interpolator_checker.sv
tb/sv/harmonic_mean_table_interpolator_tb.sv
